// ===== sv/mnfa_pkg.sv =====
// Shared constants for the multibank next-fit slot allocator.
`default_nettype none

package mnfa_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_NUM_BANKS      = 4;
   localparam int DEF_SLOTS_PER_BANK = 16;

   // Fixed port widths
   localparam int BANK_PORT_W = 2;
   localparam int SLOT_PORT_W = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 5;

   // Number of bank length registers
   localparam int NUM_LEN_REGS = 4;

   // Slots examined per scan cycle
   localparam int SCAN_W = 4;

   // Request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

endpackage

`default_nettype wire

// ===== sv/multibank_next_fit_slot_allocator_unit.sv =====
// Top level of the multibank next-fit slot allocator.
//
// Usage: drive req_type/req_bank/req_slot with start high; the item is taken
// at a clock edge where start is high and busy is low. Every item yields one
// result, shown for a single cycle with rsp_valid high on rsp_ok,
// rsp_grant_bank and rsp_grant_slot. The receiver cannot stall the block.
// Bank lengths are written through csr_valid/csr_ready, csr_index, csr_data;
// csr_ready is high while the block is idle. A length write also empties the
// bank. Reset empties every bank, sets all lengths to the full bank size and
// makes bank zero current.
// Sequence from the accepting edge to the result cycle:
//   allocate: full banks are skipped in turn (up to NUM_BANKS), then the mark
//     row is read and scanned in windows of SCAN_W slots (1 to ceil(len/SCAN_W)
//     windows); if every bank is full the item fails after one full turn.
//   free in range: mark row read, then write-back; out of range: answered at once.
// The next item may be accepted in the result cycle. The mark row is read
// through a registered memory port before the window scan or write-back.
`default_nettype none

module multibank_next_fit_slot_allocator_unit #(
   parameter int NUM_BANKS      = mnfa_pkg::DEF_NUM_BANKS,
   parameter int SLOTS_PER_BANK = mnfa_pkg::DEF_SLOTS_PER_BANK
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_type,
   input  wire logic [mnfa_pkg::BANK_PORT_W-1:0]    req_bank,
   input  wire logic [mnfa_pkg::SLOT_PORT_W-1:0]    req_slot,
   // Result channel
   output logic                                     rsp_valid,
   output logic                                     rsp_ok,
   output logic      [mnfa_pkg::BANK_PORT_W-1:0]    rsp_grant_bank,
   output logic      [mnfa_pkg::SLOT_PORT_W-1:0]    rsp_grant_slot,
   // Configuration channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mnfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mnfa_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
   localparam int SLOT_W = $clog2(SLOTS_PER_BANK);
   localparam int LEN_W  = $clog2(SLOTS_PER_BANK + 1);
   localparam logic [SLOTS_PER_BANK-1:0] ONE_ROW = {{(SLOTS_PER_BANK-1){1'b0}}, 1'b1};

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SKIP = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_FREE = 3'd4;

   // Control state
   logic [2:0]        state_ff, state_in;
   logic [BANK_W-1:0] cur_bank_ff, cur_bank_in;
   logic [LEN_W-1:0]  len_ff [NUM_BANKS];
   logic [LEN_W-1:0]  len_in [NUM_BANKS];
   logic [LEN_W-1:0]  count_ff [NUM_BANKS];
   logic [LEN_W-1:0]  count_in [NUM_BANKS];
   logic [SLOT_W-1:0] next_ff [NUM_BANKS];
   logic [SLOT_W-1:0] next_in [NUM_BANKS];
   logic              rsp_valid_ff, rsp_valid_in;

   // Item payload
   logic              type_ff, type_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [BANK_W-1:0] bank_ff, bank_in;
   logic [BANK_W-1:0] skip_ff, skip_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [SLOT_W-1:0] pos0_ff, pos0_in;
   logic [LEN_W-1:0]  done_ff, done_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [mnfa_pkg::BANK_PORT_W-1:0] rsp_bank_ff, rsp_bank_in;
   logic [mnfa_pkg::SLOT_PORT_W-1:0] rsp_slot_ff, rsp_slot_in;

   // Memory and scan hookup
   logic [SLOTS_PER_BANK-1:0] row;
   logic                      wr_en;
   logic [SLOTS_PER_BANK-1:0] wr_data;
   logic                      clr_en;
   logic [BANK_W-1:0]         clr_addr;
   logic                      found;
   logic [SLOT_W-1:0]         hit_slot;
   logic [SLOT_W-1:0]         step_pos;
   logic                      last_window;

   mnfa_mark_ram #(
      .NUM_BANKS      (NUM_BANKS),
      .SLOTS_PER_BANK (SLOTS_PER_BANK)
   ) u_mark_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (bank_ff),
      .rd_data  (row),
      .wr_en    (wr_en),
      .wr_addr  (bank_ff),
      .wr_data  (wr_data),
      .clr_en   (clr_en),
      .clr_addr (clr_addr)
   );

   mnfa_window_scan #(
      .SLOTS_PER_BANK (SLOTS_PER_BANK)
   ) u_window_scan (
      .row         (row),
      .pos         (pos_ff),
      .done_cnt    (done_ff),
      .len         (len_ff[bank_ff]),
      .found       (found),
      .hit_slot    (hit_slot),
      .step_pos    (step_pos),
      .last_window (last_window)
   );

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_grant_bank = rsp_bank_ff;
   assign rsp_grant_slot = rsp_slot_ff;

   always_comb begin
      logic [BANK_W-1:0] fb;
      logic [BANK_W-1:0] cb;
      logic [BANK_W-1:0] ci;
      logic              free_hit;

      state_in     = state_ff;
      cur_bank_in  = cur_bank_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      rsp_valid_in = 1'b0;
      type_in      = type_ff;
      slot_in      = slot_ff;
      bank_in      = bank_ff;
      skip_in      = skip_ff;
      pos_in       = pos_ff;
      pos0_in      = pos0_ff;
      done_in      = done_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_bank_in  = rsp_bank_ff;
      rsp_slot_in  = rsp_slot_ff;
      wr_en        = 1'b0;
      wr_data      = row;
      clr_en       = 1'b0;
      fb           = BANK_W'(req_bank);
      cb           = cur_bank_ff;
      ci           = BANK_W'(csr_index);
      clr_addr     = ci;
      free_hit     = row[slot_ff];

      unique case (state_ff)
         S_IDLE: begin
            // Length write: clamp to bank size and empty the bank
            if (csr_valid && int'(csr_index) < mnfa_pkg::NUM_LEN_REGS
                && int'(csr_index) < NUM_BANKS) begin
               if (int'(csr_data) > SLOTS_PER_BANK) begin
                  len_in[ci] = LEN_W'(SLOTS_PER_BANK);
               end else begin
                  len_in[ci] = LEN_W'(csr_data);
               end
               count_in[ci] = '0;
               next_in[ci]  = '0;
               clr_en       = 1'b1;
            end
            if (start) begin
               type_in = req_type;
               slot_in = SLOT_W'(req_slot);
               if (req_type == mnfa_pkg::REQ_ALLOC) begin
                  skip_in  = '0;
                  state_in = S_SKIP;
               end else if (int'(req_bank) < NUM_BANKS
                            && int'(req_slot) < int'(len_ff[fb])) begin
                  cur_bank_in = fb;
                  bank_in     = fb;
                  state_in    = S_READ;
               end else begin
                  // Free out of range: answer at once, change nothing
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_bank_in  = '0;
                  rsp_slot_in  = '0;
               end
            end
         end

         S_SKIP: begin
            if (count_ff[cb] < len_ff[cb]) begin
               bank_in  = cb;
               pos_in   = (LEN_W'(next_ff[cb]) >= len_ff[cb]) ? '0 : next_ff[cb];
               pos0_in  = (LEN_W'(next_ff[cb]) >= len_ff[cb]) ? '0 : next_ff[cb];
               done_in  = '0;
               state_in = S_READ;
            end else begin
               // Bank full: rotate, give up after one full turn
               cur_bank_in = (cb == BANK_W'(NUM_BANKS - 1)) ? '0 : cb + 1'b1;
               skip_in     = skip_ff + 1'b1;
               if (skip_ff == BANK_W'(NUM_BANKS - 1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_bank_in  = '0;
                  rsp_slot_in  = '0;
                  state_in     = S_IDLE;
               end
            end
         end

         S_READ: begin
            // Row read in flight
            state_in = (type_ff == mnfa_pkg::REQ_FREE) ? S_FREE : S_SCAN;
         end

         S_SCAN: begin
            if (found) begin
               wr_en             = 1'b1;
               wr_data           = row | (ONE_ROW << hit_slot);
               count_in[bank_ff] = count_ff[bank_ff] + 1'b1;
               next_in[bank_ff]  = ((LEN_W'(hit_slot) + 1'b1) == len_ff[bank_ff]) ?
                                   '0 : SLOT_W'(LEN_W'(hit_slot) + 1'b1);
               rsp_valid_in      = 1'b1;
               rsp_ok_in         = 1'b1;
               rsp_bank_in       = mnfa_pkg::BANK_PORT_W'(bank_ff);
               rsp_slot_in       = mnfa_pkg::SLOT_PORT_W'(hit_slot);
               state_in          = S_IDLE;
            end else if (last_window) begin
               // Whole bank scanned: pointer returns to its start
               next_in[bank_ff] = pos0_ff;
               rsp_valid_in     = 1'b1;
               rsp_ok_in        = 1'b0;
               rsp_bank_in      = '0;
               rsp_slot_in      = '0;
               state_in         = S_IDLE;
            end else begin
               pos_in  = step_pos;
               done_in = done_ff + LEN_W'(mnfa_pkg::SCAN_W);
            end
         end

         S_FREE: begin
            if (free_hit) begin
               wr_en   = 1'b1;
               wr_data = row & ~(ONE_ROW << slot_ff);
               if (count_ff[bank_ff] != '0) begin
                  count_in[bank_ff] = count_ff[bank_ff] - 1'b1;
               end
               next_in[bank_ff] = slot_ff;
            end
            rsp_valid_in = 1'b1;
            rsp_ok_in    = free_hit;
            rsp_bank_in  = '0;
            rsp_slot_in  = '0;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_bank_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BANKS; b++) begin
            len_ff[b]   <= LEN_W'(SLOTS_PER_BANK);
            count_ff[b] <= '0;
            next_ff[b]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_bank_ff  <= cur_bank_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
      end
   end

   // Payload registers: hold between updates, no reset needed
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      slot_ff     <= slot_in;
      bank_ff     <= bank_in;
      skip_ff     <= skip_in;
      pos_ff      <= pos_in;
      pos0_ff     <= pos0_in;
      done_ff     <= done_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_bank_ff <= rsp_bank_in;
      rsp_slot_ff <= rsp_slot_in;
   end

endmodule

`default_nettype wire

// ===== sv/mnfa_mark_ram.sv =====
// Used/free mark memory: one row of marks per bank, with row valid bits.
`default_nettype none

module mnfa_mark_ram #(
   parameter int NUM_BANKS      = mnfa_pkg::DEF_NUM_BANKS,
   parameter int SLOTS_PER_BANK = mnfa_pkg::DEF_SLOTS_PER_BANK,
   localparam int BANK_W        = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [BANK_W-1:0]         rd_addr,
   output logic      [SLOTS_PER_BANK-1:0] rd_data,
   input  wire logic                      wr_en,
   input  wire logic [BANK_W-1:0]         wr_addr,
   input  wire logic [SLOTS_PER_BANK-1:0] wr_data,
   input  wire logic                      clr_en,
   input  wire logic [BANK_W-1:0]         clr_addr
);

   logic [SLOTS_PER_BANK-1:0] mem [NUM_BANKS];
   logic [NUM_BANKS-1:0]      row_valid_ff;
   logic [SLOTS_PER_BANK-1:0] rd_row_ff;

   // Row valid: cleared by reset or a length write, set by any row write
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (clr_en) begin
            row_valid_ff[clr_addr] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A row never written since its last clear reads as all free
   always_ff @(posedge clock) begin
      rd_row_ff <= row_valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_row_ff;

endmodule

`default_nettype wire

// ===== sv/mnfa_window_scan.sv =====
// Window scan: checks SCAN_W consecutive slots of a row, with wrap, for a free mark.
`default_nettype none

module mnfa_window_scan #(
   parameter int SLOTS_PER_BANK = mnfa_pkg::DEF_SLOTS_PER_BANK,
   localparam int SLOT_W        = $clog2(SLOTS_PER_BANK),
   localparam int LEN_W         = $clog2(SLOTS_PER_BANK + 1)
) (
   input  wire logic [SLOTS_PER_BANK-1:0] row,
   input  wire logic [SLOT_W-1:0]         pos,
   input  wire logic [LEN_W-1:0]          done_cnt,
   input  wire logic [LEN_W-1:0]          len,
   output logic                           found,
   output logic      [SLOT_W-1:0]         hit_slot,
   output logic      [SLOT_W-1:0]         step_pos,
   output logic                           last_window
);

   localparam int SUM_W = LEN_W + 2;

   // Lowest lane that is still inside the bank and free wins
   always_comb begin
      logic [SUM_W-1:0] q;
      logic             lane_ok;
      found    = 1'b0;
      hit_slot = '0;
      for (int k = mnfa_pkg::SCAN_W - 1; k >= 0; k--) begin
         q = SUM_W'(pos) + SUM_W'(k);
         if (q >= SUM_W'(len)) begin
            q = q - SUM_W'(len);
         end
         lane_ok = ((SUM_W'(done_cnt) + SUM_W'(k)) < SUM_W'(len)) && !row[q[SLOT_W-1:0]];
         if (lane_ok) begin
            found    = 1'b1;
            hit_slot = q[SLOT_W-1:0];
         end
      end
   end

   // Advance one window with wrap; only used while more than a window remains
   always_comb begin
      logic [SUM_W-1:0] s;
      s = SUM_W'(pos) + SUM_W'(mnfa_pkg::SCAN_W);
      if (s >= SUM_W'(len)) begin
         s = s - SUM_W'(len);
      end
      step_pos    = s[SLOT_W-1:0];
      last_window = (SUM_W'(done_cnt) + SUM_W'(mnfa_pkg::SCAN_W)) >= SUM_W'(len);
   end

endmodule

`default_nettype wire
